FILE: design/first_fit_sector_allocator_assert.svh
// ----------------------------------------------------------------------------
// first_fit_sector_allocator_assert.svh
// Assertion macros shared by the allocator and its scan module.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_SECTOR_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_SECTOR_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising edge while reset is released.
`define FFSA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define FFSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFSA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FFSA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: design/ffsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_pkg
// Types, codes and constants of the first-fit sector allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  localparam int SECTOR_COUNT_DEF = 4096;
  localparam int WORD_W           = 16;
  localparam int WB               = $clog2(WORD_W);
  localparam int LEN_W            = 14;
  localparam int SECTOR_SHIFT     = 8;

  localparam logic [7:0]  MAX_FILE_NUMBER = 8'hf0;
  localparam logic [7:0]  DIR_PAGE_BASE   = 8'h80;
  localparam logic [31:0] ROUND_MASK      = 32'h0001_ffff;
  localparam logic [31:0] HW_MAX          = 32'h001f_ffff;
  localparam logic [21:0] SECTOR_ROUND    = 22'(2 ** SECTOR_SHIFT - 1);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_MARK  = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  typedef struct packed {
    logic        op;
    logic [7:0]  file_number;
    logic [20:0] file_size;
    logic [11:0] sector;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] start_offset;
    logic [7:0]  dir_start_byte;
    logic [5:0]  dir_bank;
    logic [7:0]  dir_size_low;
    logic [7:0]  dir_size_high;
    logic [20:0] used_end;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } scan_ctl_t;

  typedef struct packed {
    logic          hit;
    logic [WB-1:0] pos;
  } scan_res_t;

endpackage

FILE: design/first_fit_sector_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_sector_allocator
// First-fit allocator of contiguous 256-byte sectors over a used-sector
// bitmap held in RAM, with directory bytes and a high-water end mark.
// ----------------------------------------------------------------------------
// The bitmap is kept in one RAM of 16-bit words, so one word of sixteen
// sectors is read and tested each cycle. After reset a clearing pass writes
// one word per cycle over every word of the bitmap before the first request
// is taken. An allocation scans words from the bottom until the run fits (or
// reports full at the top), then reads and writes back every word the run
// touches. A mark request reads and writes back the word that holds its
// sector, and a rejected request goes straight to the result. One request
// is worked on at a time; a new one is taken while the previous result still
// waits in the output register.
// ----------------------------------------------------------------------------
`include "first_fit_sector_allocator_assert.svh"

module first_fit_sector_allocator #(
  parameter int SECTOR_COUNT = ffsa_pkg::SECTOR_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffsa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ffsa_pkg::out_item_t out_data
);
  import ffsa_pkg::*;

  localparam int DEPTH    = (SECTOR_COUNT + WORD_W - 1) / WORD_W;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SXW      = AW + WB;
  localparam int CW       = ((SXW > LEN_W) ? SXW : LEN_W) + 1;
  localparam int PAD_FROM = SECTOR_COUNT - (DEPTH - 1) * WORD_W;
  localparam logic [AW-1:0] LAST_W = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic [20:0]      hw_r, hw_nxt;
  in_item_t         item_r, item_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [SXW-1:0]   ss_r, ss_nxt;
  logic [SXW-1:0]   es_r, es_nxt;
  logic [1:0]       stat_r, stat_nxt;
  logic [AW-1:0]    rd_addr_r, rd_addr_nxt;
  logic             rd_go_r, rd_go_nxt;
  logic             q_vld_r, q_vld_nxt;
  logic [AW-1:0]    q_addr_r, q_addr_nxt;
  logic             s_vld_r, s_vld_nxt;
  logic [AW-1:0]    s_addr_r, s_addr_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_q;
  logic [WORD_W-1:0] pad_mask;
  logic [WORD_W-1:0] mark_mask;
  logic [WORD_W-1:0] scan_word;
  scan_ctl_t         scan_ctl;
  scan_res_t         scan_res;

  logic [SXW-1:0]   hit_end;
  logic [21:0]      len_sum;
  logic [31:0]      end_off;
  logic [31:0]      end_round;
  logic [20:0]      hw_cand;
  out_item_t        result;

  ffsa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_go_r),
    .raddr (rd_addr_r),
    .rdata (ram_q)
  );

  ffsa_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (scan_ctl),
    .word  (scan_word),
    .len   (len_r),
    .res   (scan_res)
  );

  // Sectors of the last word past SECTOR_COUNT always read as used in the scan.
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      pad_mask[i]  = (i >= PAD_FROM);
      mark_mask[i] = ({q_addr_r, WB'(i)} >= ss_r) && ({q_addr_r, WB'(i)} <= es_r);
    end
  end

  assign scan_word      = ram_q | ((q_addr_r == LAST_W) ? pad_mask : '0);
  assign scan_ctl.clear = in_valid && in_ready;
  assign scan_ctl.valid = q_vld_r && (state_r == S_SCAN);

  assign ram_we    = (state_r == S_CLEAR) || ((state_r == S_MARK) && q_vld_r);
  assign ram_waddr = (state_r == S_CLEAR) ? rd_addr_r : q_addr_r;
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : (ram_q | mark_mask);

  assign hit_end = {s_addr_r, scan_res.pos};
  assign len_sum = {1'b0, in_data.file_size} + SECTOR_ROUND;

  always_comb begin
    end_off   = (32'(ss_r) << SECTOR_SHIFT) + 32'(item_r.file_size);
    end_round = (end_off + ROUND_MASK) & ~ROUND_MASK;
    hw_cand   = (end_round > HW_MAX) ? HW_MAX[20:0] : end_round[20:0];
    hw_nxt    = hw_r;
    if ((item_r.op == OP_ALLOC) && (stat_r == ST_OK) && (32'(hw_r) < end_off)) begin
      hw_nxt = hw_cand;
    end
    result        = '0;
    result.status = stat_r;
    if ((item_r.op == OP_ALLOC) && (stat_r == ST_OK)) begin
      result.start_offset   = 20'(32'(ss_r) << SECTOR_SHIFT);
      result.dir_start_byte = DIR_PAGE_BASE + 8'(32'(ss_r) & 32'h3f);
      result.dir_bank       = 6'(32'(ss_r) >> 6);
      result.dir_size_low   = item_r.file_size[7:0];
      result.dir_size_high  = item_r.file_size[15:8]
                              - ((item_r.file_size[7:0] == 8'd0) ? 8'd1 : 8'd0);
    end
    result.used_end = hw_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    item_nxt      = item_r;
    len_nxt       = len_r;
    ss_nxt        = ss_r;
    es_nxt        = es_r;
    stat_nxt      = stat_r;
    rd_addr_nxt   = rd_addr_r;
    rd_go_nxt     = 1'b0;
    q_vld_nxt     = rd_go_r;
    q_addr_nxt    = rd_addr_r;
    s_vld_nxt     = q_vld_r && (state_r == S_SCAN);
    s_addr_nxt    = q_addr_r;
    case (state_r)
      S_CLEAR: begin
        q_vld_nxt   = 1'b0;
        rd_addr_nxt = AW'(rd_addr_r + 1'b1);
        if (rd_addr_r == LAST_W) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt    = in_data;
          stat_nxt    = ST_OK;
          rd_addr_nxt = '0;
          state_nxt   = S_DONE;
          if (in_data.op == OP_MARK) begin
            if ({20'd0, in_data.sector} < 32'(SECTOR_COUNT)) begin
              ss_nxt      = SXW'(in_data.sector);
              es_nxt      = SXW'(in_data.sector);
              rd_addr_nxt = AW'(in_data.sector >> WB);
              rd_go_nxt   = 1'b1;
              state_nxt   = S_MARK;
            end
          end else if ((in_data.file_size == 21'd0)
                       || (in_data.file_number >= MAX_FILE_NUMBER)) begin
            stat_nxt = ST_REJECT;
          end else begin
            len_nxt   = len_sum[SECTOR_SHIFT +: LEN_W];
            rd_go_nxt = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_addr_nxt = AW'(rd_addr_r + 1'b1);
        rd_go_nxt   = rd_go_r && (rd_addr_r != LAST_W);
        if (scan_res.hit) begin
          es_nxt      = hit_end;
          ss_nxt      = SXW'(CW'(hit_end) - CW'(len_r) + CW'(1));
          rd_addr_nxt = AW'(SXW'(CW'(hit_end) - CW'(len_r) + CW'(1)) >> WB);
          rd_go_nxt   = 1'b1;
          q_vld_nxt   = 1'b0;
          s_vld_nxt   = 1'b0;
          state_nxt   = S_MARK;
        end else if (s_vld_r && (s_addr_r == LAST_W)) begin
          stat_nxt  = ST_FULL;
          state_nxt = S_DONE;
        end
      end
      S_MARK: begin
        rd_addr_nxt = AW'(rd_addr_r + 1'b1);
        rd_go_nxt   = rd_go_r && (rd_addr_r != AW'(es_r >> WB));
        if (q_vld_r && (q_addr_r == AW'(es_r >> WB))) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = result;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
      hw_r        <= '0;
      rd_addr_r   <= '0;
      rd_go_r     <= 1'b0;
      q_vld_r     <= 1'b0;
      s_vld_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
        hw_r <= hw_nxt;
      end
      rd_addr_r   <= rd_addr_nxt;
      rd_go_r     <= rd_go_nxt;
      q_vld_r     <= q_vld_nxt;
      s_vld_r     <= s_vld_nxt;
    end
    out_data_r <= out_data_nxt;
    item_r     <= item_nxt;
    len_r      <= len_nxt;
    ss_r       <= ss_nxt;
    es_r       <= es_nxt;
    stat_r     <= stat_nxt;
    q_addr_r   <= q_addr_nxt;
    s_addr_r   <= s_addr_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FFSA_ASSERT(a_busy_after_transfer, clk, rst_n, in_valid && in_ready |=> state_r != S_IDLE, "request transfer left block idle")
  `FFSA_ASSERT(a_mark_only_sets, clk, rst_n, ram_we && state_r == S_MARK |-> (ram_wdata & ram_q) == ram_q, "mark write cleared a sector")
  `FFSA_ASSERT(a_done_loads_result, clk, rst_n, state_r == S_DONE && (!out_valid_r || out_ready) |=> out_valid_r && state_r == S_IDLE, "result not loaded")
  `FFSA_ASSERT(a_high_water_rises, clk, rst_n, $past(rst_n) |-> hw_r >= $past(hw_r), "high-water mark fell")

endmodule

FILE: design/ffsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ffsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/ffsa_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_scan
// Free-run detector: consumes one valid bitmap word per cycle until a hit and
// reports the first bit at which the free run reaches the requested length.
// ----------------------------------------------------------------------------
`include "first_fit_sector_allocator_assert.svh"

module ffsa_scan (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ffsa_pkg::scan_ctl_t        ctl,
  input  logic [ffsa_pkg::WORD_W-1:0] word,
  input  logic [ffsa_pkg::LEN_W-1:0] len,
  output ffsa_pkg::scan_res_t        res
);
  import ffsa_pkg::*;

  logic [LEN_W-1:0] run_r;
  logic [LEN_W-1:0] run_nxt;
  logic             hit_r;
  logic             hit_nxt;
  logic [WB-1:0]    pos_r;
  logic [WB-1:0]    pos_nxt;

  logic [LEN_W:0]   run_bit [WORD_W];
  logic [WORD_W-1:0] hit_vec;

  always_comb begin
    logic          seen;
    logic [WB-1:0] last;
    seen = 1'b0;
    last = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (word[i]) begin
        seen = 1'b1;
        last = WB'(i);
      end
      if (seen) begin
        run_bit[i] = (LEN_W + 1)'(WB'(i) - last);
      end else begin
        run_bit[i] = (LEN_W + 1)'(run_r) + (LEN_W + 1)'(i + 1);
      end
      hit_vec[i] = !word[i] && (run_bit[i] >= {1'b0, len});
    end
  end

  always_comb begin
    pos_nxt = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        pos_nxt = WB'(i);
      end
    end
    hit_nxt = |hit_vec;
    run_nxt = run_bit[WORD_W-1][LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
      hit_r <= 1'b0;
    end else if (ctl.clear) begin
      run_r <= '0;
      hit_r <= 1'b0;
    end else if (ctl.valid && !hit_r) begin
      run_r <= run_nxt;
      hit_r <= hit_nxt;
      pos_r <= pos_nxt;
    end
  end

  assign res.hit = hit_r;
  assign res.pos = pos_r;

  `FFSA_ASSERT(a_hit_needs_word, clk, rst_n, $rose(hit_r) |-> $past(ctl.valid), "hit without a word")
  `FFSA_ASSERT(a_hit_holds, clk, rst_n, hit_r && !ctl.clear |=> hit_r && $stable(pos_r), "hit lost")
  `FFSA_ASSERT(a_clear_resets, clk, rst_n, ctl.clear |=> !hit_r && run_r == '0, "clear ignored")

endmodule

FILE: dv/tb_first_fit_sector_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_sector_allocator
// Self-checking testbench for the first-fit sector allocator. A scoreboard
// keeps its own sector bitmap and high-water mark. From each accepted request
// it predicts the reply, and it compares every reply field by field in order.
// A short directed sequence covers the edge cases. It is followed by random
// allocations, sector marks and refused requests. Idling is applied on each
// side in turn, and one long result hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_first_fit_sector_allocator;
  import ffsa_pkg::*;

  localparam int SECTORS      = SECTOR_COUNT_DEF;
  localparam int RANDOM_ITEMS = 530;
  localparam int PHASE_B_AT   = 200;
  localparam int PHASE_C_AT   = 380;
  localparam int HOLD_AT      = 430;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 600;
  localparam int STALL_LIMIT  = 5000;

  class allocation_tracker;
    bit [SECTORS-1:0] sector_used;
    logic [20:0]      high_water;
    out_item_t        awaited[$];
    int               mismatches;
    int               placed;
    int               no_room;
    int               refused;
    int               marks;

    function new();
      sector_used = '0;
      high_water  = '0;
    endfunction

    function int lowest_free_run(int len);
      int run = 0;
      for (int j = 0; j < SECTORS; j++) begin
        if (sector_used[j]) begin
          run = 0;
        end else begin
          run++;
          if (run == len) return j - len + 1;
        end
      end
      return -1;
    endfunction

    function void note_request(in_item_t req);
      out_item_t   want;
      int          len;
      int          start_sector;
      logic [31:0] end_off;
      logic [31:0] rounded;
      logic [7:0]  size_high;
      want = '0;
      if (req.op == OP_MARK) begin
        sector_used[req.sector] = 1'b1;
        marks++;
      end else if (req.file_size == '0 || req.file_number >= MAX_FILE_NUMBER) begin
        want.status = ST_REJECT;
        refused++;
      end else begin
        len = (int'(req.file_size) + 255) >> 8;
        start_sector = lowest_free_run(len);
        if (start_sector < 0) begin
          want.status = ST_FULL;
          no_room++;
        end else begin
          for (int i = start_sector; i < start_sector + len; i++) sector_used[i] = 1'b1;
          size_high = req.file_size[15:8];
          if (req.file_size[7:0] == 8'h00) size_high = size_high - 8'd1;
          want.status         = ST_OK;
          want.start_offset   = 20'(start_sector * 256);
          want.dir_start_byte = DIR_PAGE_BASE + 8'(start_sector & 'h3f);
          want.dir_bank       = 6'(start_sector >> 6);
          want.dir_size_low   = req.file_size[7:0];
          want.dir_size_high  = size_high;
          end_off = 32'(start_sector * 256) + 32'(req.file_size);
          if (32'(high_water) < end_off) begin
            rounded    = (end_off + ROUND_MASK) & ~ROUND_MASK;
            high_water = (rounded > HW_MAX) ? HW_MAX[20:0] : rounded[20:0];
          end
          placed++;
        end
      end
      want.used_end = high_water;
      awaited.push_back(want);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    task check_reply(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        report($sformatf("reply %0h arrived with no request outstanding", got));
        return;
      end
      want = awaited.pop_front();
      compare_field("status", got.status, want.status);
      compare_field("start_offset", got.start_offset, want.start_offset);
      compare_field("dir_start_byte", got.dir_start_byte, want.dir_start_byte);
      compare_field("dir_bank", got.dir_bank, want.dir_bank);
      compare_field("dir_size_low", got.dir_size_low, want.dir_size_low);
      compare_field("dir_size_high", got.dir_size_high, want.dir_size_high);
      compare_field("used_end", got.used_end, want.used_end);
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int send_idle_pct = 14;
  int recv_idle_pct = 77;
  int replies_seen  = 0;
  int idle_cycles   = 0;
  bit hold_done     = 1'b0;

  allocation_tracker tracker = new();

  first_fit_sector_allocator #(
    .SECTOR_COUNT(SECTORS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_item_t pack_request(logic op, logic [7:0] fnum, logic [20:0] size,
                                            logic [11:0] sec);
    in_item_t req;
    req.op          = op;
    req.file_number = fnum;
    req.file_size   = size;
    req.sector      = sec;
    return req;
  endfunction

  task automatic send_request(input in_item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_reply(out_data);
      replies_seen++;
    end
    if (rst_n && in_valid && in_ready) tracker.note_request(in_data);
    if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // The receiver holds off once for a long stretch so that the block backs up.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && replies_seen >= HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("FAIL first_fit_sector_allocator");
    $finish;
  end

  initial begin
    in_item_t directed[$];
    in_item_t item;
    int       pick;
    int       size;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    directed.push_back(pack_request(OP_MARK, 8'h00, 21'd0, 12'd0));
    directed.push_back(pack_request(OP_MARK, 8'h00, 21'd0, 12'd1));
    directed.push_back(pack_request(OP_MARK, 8'hff, 21'h1fffff, 12'hfff));
    directed.push_back(pack_request(OP_MARK, 8'h00, 21'd0, 12'hfff));
    directed.push_back(pack_request(OP_ALLOC, 8'h00, 21'd1, 12'd0));
    directed.push_back(pack_request(OP_ALLOC, 8'hef, 21'd256, 12'd0));
    directed.push_back(pack_request(OP_ALLOC, 8'h10, 21'd0, 12'd0));
    directed.push_back(pack_request(OP_ALLOC, 8'hf0, 21'd100, 12'd0));
    directed.push_back(pack_request(OP_ALLOC, 8'hff, 21'd1048576, 12'hfff));
    directed.push_back(pack_request(OP_ALLOC, 8'h01, 21'd1048576, 12'd0));
    directed.push_back(pack_request(OP_ALLOC, 8'h02, 21'h10000, 12'd0));
    directed.push_back(pack_request(OP_MARK, 8'h5a, 21'h0aaaaa, 12'd600));
    directed.push_back(pack_request(OP_ALLOC, 8'h03, 21'd257, 12'd0));
    directed.push_back(pack_request(OP_ALLOC, 8'h04, 21'h20000, 12'd0));
    directed.push_back(pack_request(OP_ALLOC, 8'h06, 21'h2aaaa, 12'd0));
    directed.push_back(pack_request(OP_ALLOC, 8'h07, 21'h0fff00, 12'd0));
    directed.push_back(pack_request(OP_ALLOC, 8'h08, 21'd76800, 12'd0));
    directed.push_back(pack_request(OP_ALLOC, 8'he0, 21'h1ff, 12'd0));
    directed.push_back(pack_request(OP_MARK, 8'ha5, 21'h155555, 12'haaa));
    directed.push_back(pack_request(OP_MARK, 8'h3c, 21'd0, 12'h555));
    foreach (directed[i]) send_request(directed[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == PHASE_B_AT) begin
        send_idle_pct = 77;
        recv_idle_pct = 14;
      end
      if (n == PHASE_C_AT) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 12) begin
        item = pack_request(OP_MARK, 8'($urandom), 21'($urandom_range(0, 1048576)),
                            12'($urandom));
      end else if (pick < 18) begin
        if ($urandom_range(1) == 1)
          item = pack_request(OP_ALLOC, 8'($urandom_range(240, 255)),
                              21'($urandom_range(0, 1048576)), 12'($urandom));
        else
          item = pack_request(OP_ALLOC, 8'($urandom), 21'd0, 12'($urandom));
      end else begin
        pick = $urandom_range(99);
        if (pick < 75) size = $urandom_range(1, 2048);
        else if (pick < 97) size = $urandom_range(2049, 16384);
        else size = $urandom_range(16385, 1048576);
        item = pack_request(OP_ALLOC, 8'($urandom_range(0, 239)), 21'(size), 12'($urandom));
      end
      send_request(item);
    end
    in_valid <= 1'b0;

    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d placed, %0d without room, %0d refused, %0d marks.",
             tracker.placed + tracker.no_room + tracker.refused + tracker.marks,
             tracker.placed, tracker.no_room, tracker.refused, tracker.marks);
    $display("Final high-water mark %0h after idling on each side in turn and a long hold-off.",
             tracker.high_water);
    if (tracker.mismatches == 0) begin
      $display("PASS first_fit_sector_allocator");
    end else begin
      $display("FAIL first_fit_sector_allocator");
    end
    $finish;
  end

endmodule
